// ----- design/mts_pkg.sv -----
// Shared types and constants for the min-tracking stack.
`default_nettype none
package mts_pkg;

  localparam int DEPTH_DEFAULT      = 64;
  localparam int DATA_WIDTH_DEFAULT = 32;

  // operation codes carried in the request word
  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  // status codes carried in the response word
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // control sequencer
  typedef enum logic {
    S_IDLE,
    S_POP_READ
  } state_t;

endpackage
`default_nettype wire

// ----- design/mts_in_if.sv -----
// Request channel: one stack operation per word.
`default_nettype none
interface mts_in_if #(
  parameter int DATA_WIDTH = mts_pkg::DATA_WIDTH_DEFAULT
) ();
  logic                         valid;
  logic                         ready;
  logic [1:0]                   op;
  logic signed [DATA_WIDTH-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface
`default_nettype wire

// ----- design/mts_out_if.sv -----
// Response channel: stack summary after each operation.
`default_nettype none
interface mts_out_if #(
  parameter int DATA_WIDTH  = mts_pkg::DATA_WIDTH_DEFAULT,
  parameter int COUNT_WIDTH = $clog2(mts_pkg::DEPTH_DEFAULT + 1)
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] top_value;
  logic signed [DATA_WIDTH-1:0] min_value;
  logic [COUNT_WIDTH-1:0]       fill_count;
  logic                         is_empty;
  logic [1:0]                   status;

  modport source (output valid, output top_value, output min_value, output fill_count,
                  output is_empty, output status, input ready);
  modport sink   (input valid, input top_value, input min_value, input fill_count,
                  input is_empty, input status, output ready);
endinterface
`default_nettype wire

// ----- design/min_tracking_stack_core.sv -----
// Top level: bounded LIFO that also tracks the minimum of its contents.
//
//   channel | dir | payload                                          | word
//   --------+-----+--------------------------------------------------+-----------------
//   req     | in  | op, value                                        | one operation
//   rsp     | out | top_value, min_value, fill_count, is_empty, status | one summary
//
// Push, query and rejected operations give their response in the cycle after acceptance.
// A successful pop passes through S_POP_READ: the entries below the cached tops are read from
// the value and minimum RAMs (registered read data) before the response is built.
// Reset clears the counts, the sequencer, min_popped and rsp.valid; RAM contents are never cleared.
// req.ready is high when idle and the response register is empty or being taken.
`default_nettype none
module min_tracking_stack_core #(
  parameter int DEPTH      = mts_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = mts_pkg::DATA_WIDTH_DEFAULT
) (
  input wire logic clk,
  input wire logic rst,
  mts_in_if.sink   req,
  mts_out_if.source rsp
);
  import mts_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // sequencer and cached state
  state_t                       state, state_next;
  logic [CW-1:0]                vcount, vcount_next;
  logic [CW-1:0]                mcount, mcount_next;
  logic signed [DATA_WIDTH-1:0] top_reg, top_next;
  logic signed [DATA_WIDTH-1:0] min_reg, min_next;
  logic                         min_popped, min_popped_next;

  // memory ports
  logic [DATA_WIDTH-1:0] vrd_data, mrd_data;
  logic [AW-1:0]         vrd_addr, mrd_addr;

  // decode
  logic    accept, is_push, is_pop, push_ok, pop_ok, min_take, min_push, min_pop;
  logic    load_out;
  status_t status_next;

  assign accept   = req.valid && req.ready;
  assign is_push  = accept && (req.op == OP_PUSH);
  assign is_pop   = accept && (req.op == OP_POP);
  assign push_ok  = is_push && (vcount != CW'(DEPTH));
  assign pop_ok   = is_pop && (vcount != '0);
  assign min_take = (mcount == '0) || (req.value <= min_reg);
  assign min_push = push_ok && min_take && (mcount != CW'(DEPTH));
  assign min_pop  = pop_ok && (mcount != '0) && (min_reg == top_reg);

  // read the entries just below the current tops; used only after a pop
  assign vrd_addr = AW'(vcount - CW'(2));
  assign mrd_addr = AW'(mcount - CW'(2));

  mts_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_value_ram (
    .clk     (clk),
    .wr_en   (push_ok),
    .wr_addr (vcount[AW-1:0]),
    .wr_data (req.value),
    .rd_addr (vrd_addr),
    .rd_data (vrd_data)
  );

  mts_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_min_ram (
    .clk     (clk),
    .wr_en   (min_push),
    .wr_addr (mcount[AW-1:0]),
    .wr_data (req.value),
    .rd_addr (mrd_addr),
    .rd_data (mrd_data)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (pop_ok) begin
          state_next = S_POP_READ;
        end
      end
      S_POP_READ: state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // datapath and response control
  always_comb begin
    vcount_next     = vcount;
    mcount_next     = mcount;
    top_next        = top_reg;
    min_next        = min_reg;
    min_popped_next = min_popped;
    status_next     = ST_OK;
    load_out        = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (is_push && !push_ok) begin
            status_next = ST_OVERFLOW;
          end else if (is_pop && !pop_ok) begin
            status_next = ST_UNDERFLOW;
          end
          if (push_ok) begin
            vcount_next = vcount + CW'(1);
            top_next    = req.value;
          end
          if (min_push) begin
            mcount_next = mcount + CW'(1);
            min_next    = req.value;
          end
          if (pop_ok) begin
            vcount_next     = vcount - CW'(1);
            min_popped_next = min_pop;
            if (min_pop) begin
              mcount_next = mcount - CW'(1);
            end
          end else begin
            load_out = 1'b1;
          end
        end
      end
      S_POP_READ: begin
        load_out = 1'b1;
        if (vcount != '0) begin
          top_next = $signed(vrd_data);
        end
        if (min_popped && (mcount != '0)) begin
          min_next = $signed(mrd_data);
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      vcount     <= '0;
      mcount     <= '0;
      min_popped <= 1'b0;
      rsp.valid  <= 1'b0;
    end else begin
      state      <= state_next;
      vcount     <= vcount_next;
      mcount     <= mcount_next;
      min_popped <= min_popped_next;
      if (load_out) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // cached tops and response word
  always_ff @(posedge clk) begin
    top_reg <= top_next;
    min_reg <= min_next;
    if (load_out) begin
      rsp.top_value  <= (vcount_next != '0) ? top_next : '0;
      rsp.min_value  <= ((vcount_next != '0) && (mcount_next != '0)) ? min_next : '0;
      rsp.fill_count <= vcount_next;
      rsp.is_empty   <= (vcount_next == '0);
      rsp.status     <= status_next;
    end
  end

  assign req.ready = (state == S_IDLE) && (!rsp.valid || rsp.ready);

endmodule
`default_nettype wire

// ----- design/mts_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mts_ram #(
  parameter int WIDTH = mts_pkg::DATA_WIDTH_DEFAULT,
  parameter int DEPTH = mts_pkg::DEPTH_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire
